>>> rtl/adfpc_pkg.sv
// Shared types and constants for the advertising data filter with peer cache.
package adfpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int NAME_BYTES_DEF    = 8;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [7:0] AD_NAME_SHORT = 8'h08;
    localparam logic [7:0] AD_NAME_FULL  = 8'h09;
    localparam logic [7:0] AD_SVC_PART   = 8'h02;
    localparam logic [7:0] AD_SVC_FULL   = 8'h03;

    localparam logic       REQ_DATA  = 1'b0;
    localparam logic       REQ_CLEAR = 1'b1;

    localparam logic [1:0] REG_TARGET_NAME = 2'd0;
    localparam logic [1:0] REG_NAME_LENGTH = 2'd1;
    localparam logic [1:0] REG_SERVICE_ID  = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  adv_byte;
        logic        last_byte;
        logic [47:0] peer_address;
        logic [1:0]  address_kind;
    } t_in_item;

    typedef struct packed {
        logic       name_found;
        logic       service_found;
        logic [2:0] slot_index;
        logic       slot_evicted;
        logic       name_seen_flag;
        logic       service_seen_flag;
        logic       connect_candidate;
    } t_out_item;

    // Classified work passed from parser to cache.
    typedef struct packed {
        logic        clear;
        logic        name_hit;
        logic        service_hit;
        logic [49:0] key;
    } t_cmd;

endpackage

>>> rtl/adfpc_parser.sv
// Front part: parses report bytes and emits one cache command per report end or clear.
module adfpc_parser #(
    parameter int NAME_BYTES = adfpc_pkg::NAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  adfpc_pkg::t_in_item i_item,
    input  logic [63:0]        i_target_name,
    input  logic [3:0]         i_name_length,
    input  logic [15:0]        i_service_id,
    output logic               o_cmd_valid,
    output adfpc_pkg::t_cmd    o_cmd
);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_len, n_len;
    logic [7:0] r_kind, n_kind;
    logic       r_stop, n_stop;
    logic       r_nok, n_nok;
    logic [7:0] r_low, n_low;
    logic       r_psvc, n_psvc;
    logic       r_nhit, n_nhit;
    logic       r_shit, n_shit;

    logic [7:0] v;
    logic [7:0] b;
    logic [7:0] tb;
    logic       name_hit, svc_hit;

    assign b = i_item.adv_byte;

    always_comb begin
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_len  = r_len;
        n_kind = r_kind;
        n_stop = r_stop;
        n_nok  = r_nok;
        n_low  = r_low;
        n_psvc = r_psvc;
        n_nhit = r_nhit;
        n_shit = r_shit;
        v      = r_pos - r_hdr - 8'd2;
        tb     = i_target_name[{v[2:0], 3'b000} +: 8];
        if (r_pos != 8'd255 && !r_stop) begin
            if (r_pos == r_hdr) begin
                if (b == 8'd0) n_stop = 1'b1;
                else           n_len  = b;
            end else begin
                if (r_pos == r_hdr + 8'd1) begin
                    n_kind = b;
                    n_nok  = 1'b1;
                    n_psvc = 1'b0;
                    n_low  = 8'd0;
                end else begin
                    if (v < 8'(NAME_BYTES) && tb != b) n_nok = 1'b0;
                    if (!v[0])                              n_low  = b;
                    else if ({b, r_low} == i_service_id)    n_psvc = 1'b1;
                end
                if (r_pos == r_hdr + r_len) begin
                    if ((n_kind == adfpc_pkg::AD_NAME_SHORT ||
                         n_kind == adfpc_pkg::AD_NAME_FULL) && n_nok &&
                        i_name_length <= 4'(NAME_BYTES) &&
                        r_len - 8'd1 == {4'd0, i_name_length})
                        n_nhit = 1'b1;
                    if ((n_kind == adfpc_pkg::AD_SVC_PART ||
                         n_kind == adfpc_pkg::AD_SVC_FULL) && n_psvc)
                        n_shit = 1'b1;
                    n_hdr = r_pos + 8'd1;
                end
            end
        end
        if (r_pos != 8'd255) n_pos = r_pos + 8'd1;
        name_hit = n_nhit;
        svc_hit  = n_shit;
    end

    assign o_cmd_valid = i_valid &&
                         (i_item.req_type == adfpc_pkg::REQ_CLEAR || i_item.last_byte);
    assign o_cmd.clear       = (i_item.req_type == adfpc_pkg::REQ_CLEAR);
    assign o_cmd.name_hit    = name_hit;
    assign o_cmd.service_hit = svc_hit;
    assign o_cmd.key         = {i_item.address_kind, i_item.peer_address};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && (i_item.req_type == adfpc_pkg::REQ_CLEAR ||
                                     i_item.last_byte))) begin
            r_pos  <= 8'd0;
            r_hdr  <= 8'd0;
            r_len  <= 8'd0;
            r_kind <= 8'd0;
            r_stop <= 1'b0;
            r_nok  <= 1'b1;
            r_low  <= 8'd0;
            r_psvc <= 1'b0;
            r_nhit <= 1'b0;
            r_shit <= 1'b0;
        end else if (i_valid) begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_len  <= n_len;
            r_kind <= n_kind;
            r_stop <= n_stop;
            r_nok  <= n_nok;
            r_low  <= n_low;
            r_psvc <= n_psvc;
            r_nhit <= n_nhit;
            r_shit <= n_shit;
        end
    end

endmodule

>>> rtl/adfpc_fifo.sv
// Small register queue used between parser and cache, and on the result side.
module adfpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = adfpc_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (do_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

>>> rtl/adfpc_cache.sv
// Back part: peer cache lookup, allocation and flag update.
module adfpc_cache #(
    parameter int CACHE_ENTRIES = adfpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  adfpc_pkg::t_cmd      i_cmd,
    output logic                 o_res_valid,
    output adfpc_pkg::t_out_item o_res
);

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [CACHE_ENTRIES-1:0] r_valid, r_nseen, r_sseen;
    logic [49:0]              r_addr [CACHE_ENTRIES];

    logic          found, free_found, any_hit, evict, ns, ss;
    logic [IW-1:0] hit_slot, open_slot, slot;

    always_comb begin
        found      = 1'b0;
        free_found = 1'b0;
        hit_slot   = '0;
        open_slot  = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_addr[i] == i_cmd.key) begin
                found    = 1'b1;
                hit_slot = IW'(i);
            end
            if (!r_valid[i]) begin
                free_found = 1'b1;
                open_slot  = IW'(i);
            end
        end
        any_hit = i_cmd.name_hit || i_cmd.service_hit;
        evict   = !found && !free_found;
        slot    = found ? hit_slot : (free_found ? open_slot : '0);
        ns      = (found && r_nseen[slot]) || i_cmd.name_hit;
        ss      = (found && r_sseen[slot]) || i_cmd.service_hit;
    end

    assign o_res_valid = i_valid && !i_cmd.clear;

    always_comb begin
        o_res = '0;
        if (any_hit) begin
            o_res.name_found        = i_cmd.name_hit;
            o_res.service_found     = i_cmd.service_hit;
            o_res.slot_index        = 3'(slot);
            o_res.slot_evicted      = evict;
            o_res.name_seen_flag    = ns;
            o_res.service_seen_flag = ss;
            o_res.connect_candidate = ns && ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !i_cmd.clear && any_hit && !found) r_addr[slot] <= i_cmd.key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_cmd.clear)) begin
            r_valid <= '0;
            r_nseen <= '0;
            r_sseen <= '0;
        end else if (i_valid && any_hit) begin
            r_valid[slot] <= 1'b1;
            r_nseen[slot] <= ns;
            r_sseen[slot] <= ss;
        end
    end

endmodule

>>> rtl/adv_data_filter_with_peer_cache_unit.sv
// Advertising data filter: parses report bytes one per cycle while full is low, updates a peer cache.
// Throughput: one byte per cycle unless full is high, which the command queue raises when it fills.
// A report's command is registered in the command queue, then its cache result in the result queue.
// Command and result queues hold four entries each; full rises only when both back up.
// Reset (synchronous, active low) clears parser, cache valid/flags, queues and registers.
module adv_data_filter_with_peer_cache_unit #(
    parameter int CACHE_ENTRIES = adfpc_pkg::CACHE_ENTRIES_DEF,
    parameter int NAME_BYTES    = adfpc_pkg::NAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  adfpc_pkg::t_in_item  i_item,
    output logic                 empty,
    input  logic                 pop,
    output adfpc_pkg::t_out_item o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic [63:0] r_name;
    logic [3:0]  r_nlen;
    logic [15:0] r_svc;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name <= '0;
            r_nlen <= '0;
            r_svc  <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2:0] == 3'd0) begin
                unique case (reg_idx)
                    adfpc_pkg::REG_TARGET_NAME: r_name <= pwdata;
                    adfpc_pkg::REG_NAME_LENGTH: r_nlen <= pwdata[3:0];
                    adfpc_pkg::REG_SERVICE_ID:  r_svc  <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            adfpc_pkg::REG_TARGET_NAME: prdata = r_name;
            adfpc_pkg::REG_NAME_LENGTH: prdata = {60'd0, r_nlen};
            adfpc_pkg::REG_SERVICE_ID:  prdata = {48'd0, r_svc};
            default:                    prdata = '0;
        endcase
    end

    logic            in_acc, cmd_v, cq_full, cq_empty, cq_pop, res_v, rq_full;
    adfpc_pkg::t_cmd cmd, cq_data;
    adfpc_pkg::t_out_item res;

    assign full   = cq_full;
    assign in_acc = push && !full;

    adfpc_parser #(.NAME_BYTES(NAME_BYTES)) u_parser (
        .i_clk, .i_rst_n, .i_valid(in_acc), .i_item,
        .i_target_name(r_name), .i_name_length(r_nlen), .i_service_id(r_svc),
        .o_cmd_valid(cmd_v), .o_cmd(cmd)
    );

    adfpc_fifo #(.WIDTH($bits(adfpc_pkg::t_cmd))) u_cmdq (
        .i_clk, .i_rst_n, .i_push(cmd_v), .i_data(cmd), .o_full(cq_full),
        .i_pop(cq_pop), .o_empty(cq_empty), .o_data(cq_data)
    );

    // Clears retire without a result; otherwise wait for result space.
    assign cq_pop = !cq_empty && (cq_data.clear || !rq_full);

    adfpc_cache #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_cache (
        .i_clk, .i_rst_n, .i_valid(cq_pop), .i_cmd(cq_data),
        .o_res_valid(res_v), .o_res(res)
    );

    adfpc_fifo #(.WIDTH($bits(adfpc_pkg::t_out_item))) u_resq (
        .i_clk, .i_rst_n, .i_push(res_v), .i_data(res), .o_full(rq_full),
        .i_pop(pop), .o_empty(empty), .o_data(o_item)
    );

`ifndef SYNTHESIS
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_v |-> !rq_full) else $error("result pushed into full queue");
    a_cmd_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_v |-> !cq_full) else $error("command lost");
    a_clear_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cq_pop && cq_data.clear) |-> !res_v) else $error("clear produced result");
`endif

endmodule

>>> verif/tb_top.sv
// Testbench for the advertising data filter with peer cache: queue-side traffic with scoreboard.
`timescale 1ns / 100ps
module tb_top;

    class peer_filter_sb;
        logic [63:0] cfg_name;
        logic [3:0]  cfg_name_len;
        logic [15:0] cfg_svc;
        logic [7:0]  pos, hdr, slen, skind, lo_hold;
        bit          stopped, name_ok, svc_pend, rep_name, rep_svc;
        bit          ent_valid [8];
        logic [49:0] ent_key [8];
        bit          ent_name [8];
        bit          ent_svc [8];
        adfpc_pkg::t_out_item pending_results[$];
        int          mismatches;

        function void parser_reset();
            pos = '0; hdr = '0; slen = '0; skind = '0; lo_hold = '0;
            stopped = 1'b0; name_ok = 1'b1; svc_pend = 1'b0; rep_name = 1'b0; rep_svc = 1'b0;
        endfunction

        function void cache_reset();
            for (int i = 0; i < 8; i++) begin
                ent_valid[i] = 1'b0; ent_key[i] = '0; ent_name[i] = 1'b0; ent_svc[i] = 1'b0;
            end
        endfunction

        function void power_on();
            cfg_name = '0; cfg_name_len = '0; cfg_svc = '0;
            parser_reset();
            cache_reset();
            mismatches = 0;
        endfunction

        function void parse(logic [7:0] b);
            int v;
            if (stopped) return;
            if (pos == hdr) begin
                if (b == 8'd0) stopped = 1'b1;
                else slen = b;
                return;
            end
            if (int'(pos) == int'(hdr) + 1) begin
                skind = b; name_ok = 1'b1; svc_pend = 1'b0; lo_hold = '0;
            end else begin
                v = int'(pos) - int'(hdr) - 2;
                if (v < 8 && cfg_name[8*v +: 8] != b) name_ok = 1'b0;
                if (v % 2 == 0) lo_hold = b;
                else if ({b, lo_hold} == cfg_svc) svc_pend = 1'b1;
            end
            if (int'(pos) == int'(hdr) + int'(slen)) begin
                if ((skind == adfpc_pkg::AD_NAME_SHORT || skind == adfpc_pkg::AD_NAME_FULL) &&
                    name_ok && cfg_name_len <= 4'd8 && int'(slen) - 1 == int'(cfg_name_len))
                    rep_name = 1'b1;
                if ((skind == adfpc_pkg::AD_SVC_PART || skind == adfpc_pkg::AD_SVC_FULL) &&
                    svc_pend)
                    rep_svc = 1'b1;
                hdr = pos + 8'd1;
            end
        endfunction

        function void note_item(adfpc_pkg::t_in_item it);
            adfpc_pkg::t_out_item r;
            int slot, open_slot;
            bit hit, have_free;
            logic [49:0] key;
            if (it.req_type == adfpc_pkg::REQ_CLEAR) begin
                cache_reset(); parser_reset(); return;
            end
            if (pos < 8'd255) begin
                parse(it.adv_byte);
                pos++;
            end
            if (!it.last_byte) return;
            r = '0;
            if (rep_name || rep_svc) begin
                key = {it.address_kind, it.peer_address};
                slot = 0; open_slot = 0; hit = 1'b0; have_free = 1'b0;
                for (int i = 0; i < 8; i++) begin
                    if (ent_valid[i] && ent_key[i] == key) begin
                        slot = i; hit = 1'b1; break;
                    end
                    if (!ent_valid[i] && !have_free) begin
                        open_slot = i; have_free = 1'b1;
                    end
                end
                if (!hit) begin
                    if (have_free) slot = open_slot;
                    else begin
                        slot = 0; r.slot_evicted = 1'b1;
                    end
                    ent_valid[slot] = 1'b1; ent_key[slot] = key;
                    ent_name[slot] = 1'b0; ent_svc[slot] = 1'b0;
                end
                ent_name[slot] |= rep_name;
                ent_svc[slot] |= rep_svc;
                r.name_found = rep_name;
                r.service_found = rep_svc;
                r.slot_index = slot[2:0];
                r.name_seen_flag = ent_name[slot];
                r.service_seen_flag = ent_svc[slot];
                r.connect_candidate = ent_name[slot] && ent_svc[slot];
            end
            pending_results.push_back(r);
            parser_reset();
        endfunction

        function void check_result(adfpc_pkg::t_out_item got);
            adfpc_pkg::t_out_item exp_r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: exp %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        push, full, empty, pop;
    adfpc_pkg::t_in_item  i_item;
    adfpc_pkg::t_out_item o_item;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [63:0] pwdata, prdata;

    peer_filter_sb sb;
    int          hold_off;

    adv_data_filter_with_peer_cache_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Accepted transfers on both sides, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_item(i_item);
            if (pop && !empty) sb.check_result(o_item);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int w;
        pop = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                pop <= 0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
                pop <= 0;
                repeat (w) @(negedge i_clk);
            end
            pop <= 1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            adfpc_pkg::REG_TARGET_NAME: sb.cfg_name = val;
            adfpc_pkg::REG_NAME_LENGTH: sb.cfg_name_len = val[3:0];
            default:                    sb.cfg_svc = val[15:0];
        endcase
    endtask

    task automatic send_item(adfpc_pkg::t_in_item it, bit no_gap);
        int w;
        w = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        if (w > 0) begin
            push <= 0;
            repeat (w) @(negedge i_clk);
        end
        push <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b, bit last, bit no_gap);
        adfpc_pkg::t_in_item it;
        it.req_type = adfpc_pkg::REQ_DATA;
        it.adv_byte = b;
        it.last_byte = last;
        it.peer_address = {2'($urandom_range(0, 3)), 46'h0} |
                          {16'h0, 32'($urandom_range(0, 3))};
        it.address_kind = 2'($urandom_range(0, 3));
        send_item(it, no_gap);
    endtask

    task automatic send_clear();
        adfpc_pkg::t_in_item it;
        it = 60'({$urandom, $urandom});
        it.req_type = adfpc_pkg::REQ_CLEAR;
        send_item(it, 0);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Build one report: name/service structures mixed with noise, optional stop, cut or pad, peer key.
    task automatic send_report(int style, bit no_gap);
        logic [7:0] buf_q[$];
        logic [47:0] addr;
        logic [1:0]  kind;
        adfpc_pkg::t_in_item it;
        int n, len;
        n = $urandom_range(1, 4);
        for (int s = 0; s < n; s++) begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : sb.cfg_name_len;
                    buf_q.push_back(8'(len + 1));
                    buf_q.push_back($urandom_range(0, 1) ? adfpc_pkg::AD_NAME_FULL :
                                                           adfpc_pkg::AD_NAME_SHORT);
                    for (int k = 0; k < len; k++)
                        buf_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                        (k < 8 ? sb.cfg_name[8*k +: 8] : 8'($urandom)));
                end
                2, 3: begin
                    len = $urandom_range(0, 7);
                    buf_q.push_back(8'(len + 1));
                    buf_q.push_back($urandom_range(0, 1) ? adfpc_pkg::AD_SVC_FULL :
                                                           adfpc_pkg::AD_SVC_PART);
                    for (int k = 0; k < len; k++)
                        buf_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom) :
                                        (k % 2 ? sb.cfg_svc[15:8] : sb.cfg_svc[7:0]));
                end
                default: begin
                    len = $urandom_range(0, 5);
                    buf_q.push_back(8'(len + 1));
                    buf_q.push_back(8'($urandom));
                    for (int k = 0; k < len; k++) buf_q.push_back(8'($urandom));
                end
            endcase
        end
        if (style == 1) buf_q.push_back(8'd0);
        if (style == 2 && buf_q.size() > 1) void'(buf_q.pop_back());
        if (style == 3) for (int k = 0; k < 5; k++) buf_q.push_back(8'($urandom));
        addr = {$urandom_range(0, 1) ? 46'h0 : {14'($urandom), 32'($urandom)},
                2'($urandom_range(0, 3))};
        if ($urandom_range(0, 1)) addr = {45'h0, 3'($urandom_range(0, 11))};
        kind = $urandom_range(0, 1) ? 2'd0 : 2'($urandom);
        foreach (buf_q[k]) begin
            it = '0;
            it.req_type = adfpc_pkg::REQ_DATA;
            it.adv_byte = buf_q[k];
            it.last_byte = (k == buf_q.size() - 1);
            it.peer_address = it.last_byte ? addr : {16'($urandom), 32'($urandom)};
            it.address_kind = it.last_byte ? kind : 2'($urandom);
            send_item(it, no_gap);
        end
    endtask

    initial begin
        sb = new();
        sb.power_on();
        i_rst_n = 0; push = 0; i_item = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_off = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: name match at name length zero, zero length stop, service match, cut-short structure.
        reg_write(adfpc_pkg::REG_TARGET_NAME, 64'h0);
        reg_write(adfpc_pkg::REG_NAME_LENGTH, 64'd0);
        reg_write(adfpc_pkg::REG_SERVICE_ID, 64'hFFFF);
        send_byte(8'h01, 0, 0); send_byte(adfpc_pkg::AD_NAME_FULL, 1, 0);
        send_byte(8'h00, 0, 0); send_byte(8'hFF, 1, 0);
        send_byte(8'h04, 0, 0); send_byte(adfpc_pkg::AD_SVC_FULL, 0, 0);
        send_byte(8'hFF, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'hAA, 1, 0);
        send_byte(8'h05, 0, 0); send_byte(adfpc_pkg::AD_SVC_PART, 0, 0); send_byte(8'hFF, 1, 0);
        send_clear();
        drain();
        reg_write(adfpc_pkg::REG_TARGET_NAME, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(adfpc_pkg::REG_NAME_LENGTH, 64'd8);
        reg_write(adfpc_pkg::REG_SERVICE_ID, 64'h0);
        // Long report past 255 bytes, closed by its final mark.
        send_byte(8'h09, 0, 1); send_byte(adfpc_pkg::AD_NAME_SHORT, 0, 1);
        for (int k = 0; k < 8; k++) send_byte(8'hFF, 0, 1);
        for (int k = 0; k < 250; k++) send_byte(8'h00, 0, 1);
        send_byte(8'h00, 1, 1);
        drain();
        reg_write(adfpc_pkg::REG_NAME_LENGTH, 64'd15);
        send_byte(8'h02, 0, 0); send_byte(adfpc_pkg::AD_NAME_FULL, 0, 0); send_byte(8'hFF, 1, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            reg_write(adfpc_pkg::REG_TARGET_NAME, {$urandom, $urandom});
            reg_write(adfpc_pkg::REG_NAME_LENGTH,
                      (ph == 5) ? 64'd9 : 64'($urandom_range(0, 8)));
            reg_write(adfpc_pkg::REG_SERVICE_ID, (ph == 0) ? 64'hFFFF : 64'($urandom));
            for (int r = 0; r < 20; r++) begin
                if (ph == 2 && r == 10) hold_off = 200;
                if ($urandom_range(0, 29) == 0) send_clear();
                else send_report(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                                 ph == 2 && r >= 10 && r < 20);
            end
            drain();
        end
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> adv_data_filter_with_peer_cache_unit.f
rtl/adfpc_pkg.sv
rtl/adfpc_parser.sv
rtl/adfpc_fifo.sv
rtl/adfpc_cache.sv
rtl/adv_data_filter_with_peer_cache_unit.sv
verif/tb_top.sv
